// ----- hdl/ir2pd_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ir2pd_pkg
// shared types and constants of the ir two-bit pulse-distance modulator
// ----------------------------------------------------------------------------
package ir2pd_pkg;

  // configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 20;

  localparam logic [CFG_IDX_W-1:0] REG_CARRIER_HALF = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BURST_CYCLES = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PAUSE_SYM0   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_PAUSE_SYM1   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_PAUSE_SYM2   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_PAUSE_SYM3   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_GAP_TICKS    = 3'd6;

  // register reset values
  localparam logic [7:0]  RST_CARRIER_HALF = 8'd4;
  localparam logic [9:0]  RST_BURST_CYCLES = 10'd48;
  localparam logic [15:0] RST_PAUSE_SYM0   = 16'd560;
  localparam logic [15:0] RST_PAUSE_SYM1   = 16'd2370;
  localparam logic [15:0] RST_PAUSE_SYM2   = 16'd1170;
  localparam logic [15:0] RST_PAUSE_SYM3   = 16'd1780;
  localparam logic [19:0] RST_GAP_TICKS    = 20'd20000;

  // load status codes
  localparam logic [1:0] LS_OK   = 2'd0;
  localparam logic [1:0] LS_BUSY = 2'd1;
  localparam logic [1:0] LS_FULL = 2'd2;

  // request types
  localparam logic REQ_LOAD = 1'b0;
  localparam logic REQ_TICK = 1'b1;

  typedef struct packed {
    logic        req_type;
    logic [7:0]  data_byte;
    logic        last_byte;
    logic [15:0] repeat_count;
  } req_word_t;

  typedef struct packed {
    logic       ir_level;
    logic       busy_res;
    logic [1:0] load_status;
    logic       frame_done;
  } res_word_t;

  // controller to datapath
  typedef struct packed {
    logic load_byte;
    logic clear_len;
    logic start;
    logic burst_step;
    logic load_pause;
    logic interval_dec;
    logic begin_burst;
    logic next_symbol;
    logic load_gap;
    logic restart;
    logic end_frame;
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic burst_done;
    logic interval_one;
    logic last_symbol;
    logic gap_zero;
    logic repeats_le1;
    logic full;
    logic rep_zero;
  } dp_stat_t;

endpackage

// ----- hdl/ir2pd_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ir2pd_ram
// generic single-write, single-read ram with registered read data
// ----------------------------------------------------------------------------
module ir2pd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [WIDTH-1:0]  wr_data,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [WIDTH-1:0]  rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// ----- hdl/ir2pd_dpath.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ir2pd_dpath
// frame store, configuration registers, carrier and interval counters
// ----------------------------------------------------------------------------
module ir2pd_dpath #(
  parameter int FRAME_BYTES = 256
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [ir2pd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [ir2pd_pkg::CFG_DATA_W-1:0] cfg_data,
  input  ir2pd_pkg::req_word_t             req,
  input  ir2pd_pkg::dp_cmd_t               cmd,
  output ir2pd_pkg::dp_stat_t              stat,
  output logic                             pin_level
);

  localparam int ADDR_W = (FRAME_BYTES > 1) ? $clog2(FRAME_BYTES) : 1;
  localparam int LEN_W  = $clog2(FRAME_BYTES + 1);
  localparam int POS_W  = ADDR_W + 2;
  localparam int CMP_W  = (LEN_W + 2 > POS_W + 1) ? LEN_W + 2 : POS_W + 1;

  // configuration
  logic [7:0]  carrier_half;
  logic [9:0]  burst_cycles;
  logic [15:0] pause0, pause1, pause2, pause3;
  logic [19:0] gap_ticks;

  // frame state
  logic [LEN_W-1:0] frame_length, frame_length_next;
  logic [15:0]      repeats_left, repeats_left_next;
  logic [POS_W-1:0] symbol_position, symbol_position_next;
  logic [19:0]      interval_counter, interval_counter_next;
  logic [7:0]       half_counter, half_counter_next;
  logic [9:0]       cycles_left, cycles_left_next;
  logic             pin_level_next;

  logic [7:0]       rd_data;
  logic [1:0]       symbol;
  logic [15:0]      pause_sel;
  logic [7:0]       half_reload;
  logic [9:0]       cycles_reload;
  logic [CMP_W-1:0] pos_inc, len_syms;

  always_ff @(posedge clk) begin
    if (rst) begin
      carrier_half <= ir2pd_pkg::RST_CARRIER_HALF;
      burst_cycles <= ir2pd_pkg::RST_BURST_CYCLES;
      pause0       <= ir2pd_pkg::RST_PAUSE_SYM0;
      pause1       <= ir2pd_pkg::RST_PAUSE_SYM1;
      pause2       <= ir2pd_pkg::RST_PAUSE_SYM2;
      pause3       <= ir2pd_pkg::RST_PAUSE_SYM3;
      gap_ticks    <= ir2pd_pkg::RST_GAP_TICKS;
    end else if (cfg_we) begin
      case (cfg_index)
        ir2pd_pkg::REG_CARRIER_HALF: carrier_half <= cfg_data[7:0];
        ir2pd_pkg::REG_BURST_CYCLES: burst_cycles <= cfg_data[9:0];
        ir2pd_pkg::REG_PAUSE_SYM0:   pause0 <= cfg_data[15:0];
        ir2pd_pkg::REG_PAUSE_SYM1:   pause1 <= cfg_data[15:0];
        ir2pd_pkg::REG_PAUSE_SYM2:   pause2 <= cfg_data[15:0];
        ir2pd_pkg::REG_PAUSE_SYM3:   pause3 <= cfg_data[15:0];
        ir2pd_pkg::REG_GAP_TICKS:    gap_ticks <= cfg_data;
        default: ;
      endcase
    end
  end

  // read address follows the current byte; it is stable over a whole burst
  ir2pd_ram #(
    .WIDTH (8),
    .DEPTH (FRAME_BYTES),
    .ADDR_W(ADDR_W)
  ) u_store (
    .clk    (clk),
    .we     (cmd.load_byte),
    .wr_addr(ADDR_W'(frame_length)),
    .wr_data(req.data_byte),
    .rd_addr(symbol_position[POS_W-1:2]),
    .rd_data(rd_data)
  );

  // msb-first symbol of the stored byte
  always_comb begin
    case (symbol_position[1:0])
      2'd0:    symbol = rd_data[7:6];
      2'd1:    symbol = rd_data[5:4];
      2'd2:    symbol = rd_data[3:2];
      default: symbol = rd_data[1:0];
    endcase
    case (symbol)
      2'd0:    pause_sel = pause0;
      2'd1:    pause_sel = pause1;
      2'd2:    pause_sel = pause2;
      default: pause_sel = pause3;
    endcase
    if (pause_sel == 16'd0) begin
      pause_sel = 16'd1;
    end
  end

  assign half_reload   = (carrier_half == 8'd0) ? 8'd1 : carrier_half;
  assign cycles_reload = (burst_cycles == 10'd0) ? 10'd1 : burst_cycles;
  assign pos_inc       = CMP_W'(symbol_position) + CMP_W'(1);
  assign len_syms      = CMP_W'({frame_length, 2'b00});

  assign stat.burst_done   = (half_counter == 8'd1) && !pin_level && (cycles_left == 10'd1);
  assign stat.interval_one = (interval_counter == 20'd1);
  assign stat.last_symbol  = (pos_inc >= len_syms);
  assign stat.gap_zero     = (gap_ticks == 20'd0);
  assign stat.repeats_le1  = (repeats_left <= 16'd1);
  assign stat.full         = (frame_length == LEN_W'(FRAME_BYTES));
  assign stat.rep_zero     = (req.repeat_count == 16'd0);

  always_comb begin
    frame_length_next     = frame_length;
    repeats_left_next     = repeats_left;
    symbol_position_next  = symbol_position;
    interval_counter_next = interval_counter;
    half_counter_next     = half_counter;
    cycles_left_next      = cycles_left;
    pin_level_next        = pin_level;

    if (cmd.load_byte) begin
      frame_length_next = frame_length + LEN_W'(1);
    end
    if (cmd.clear_len || cmd.end_frame) begin
      frame_length_next = '0;
    end

    if (cmd.start) begin
      repeats_left_next = req.repeat_count;
    end
    if ((cmd.restart || cmd.end_frame) && repeats_left != 16'd0) begin
      repeats_left_next = repeats_left - 16'd1;
    end

    if (cmd.next_symbol) begin
      symbol_position_next = symbol_position + POS_W'(1);
    end
    if (cmd.start || cmd.restart || cmd.end_frame) begin
      symbol_position_next = '0;
    end

    // carrier: high half, low half, then count the cycle
    if (cmd.burst_step) begin
      half_counter_next = half_counter - 8'd1;
      if (half_counter == 8'd1) begin
        if (pin_level) begin
          pin_level_next    = 1'b0;
          half_counter_next = half_reload;
        end else begin
          cycles_left_next = cycles_left - 10'd1;
          if (cycles_left != 10'd1) begin
            pin_level_next    = 1'b1;
            half_counter_next = half_reload;
          end
        end
      end
    end
    if (cmd.start || cmd.begin_burst || cmd.restart) begin
      pin_level_next    = 1'b1;
      half_counter_next = half_reload;
      cycles_left_next  = cycles_reload;
    end
    if (cmd.end_frame) begin
      pin_level_next = 1'b0;
    end

    if (cmd.interval_dec) begin
      interval_counter_next = interval_counter - 20'd1;
    end
    if (cmd.load_pause) begin
      interval_counter_next = 20'(pause_sel);
    end
    if (cmd.load_gap) begin
      interval_counter_next = gap_ticks;
    end
    if (cmd.end_frame) begin
      interval_counter_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_length     <= '0;
      repeats_left     <= '0;
      symbol_position  <= '0;
      interval_counter <= '0;
      half_counter     <= '0;
      cycles_left      <= '0;
      pin_level        <= 1'b0;
    end else begin
      frame_length     <= frame_length_next;
      repeats_left     <= repeats_left_next;
      symbol_position  <= symbol_position_next;
      interval_counter <= interval_counter_next;
      half_counter     <= half_counter_next;
      cycles_left      <= cycles_left_next;
      pin_level        <= pin_level_next;
    end
  end

endmodule

// ----- hdl/ir2pd_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ir2pd_ctrl
// phase state machine, handshake and result status registers
// ----------------------------------------------------------------------------
module ir2pd_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                req_valid,
  output logic                req_stall,
  input  logic                req_type,
  input  logic                last_byte,
  output logic                res_valid,
  input  logic                res_stall,
  input  ir2pd_pkg::dp_stat_t stat,
  output ir2pd_pkg::dp_cmd_t  cmd,
  output logic                busy,
  output logic [1:0]          load_status,
  output logic                frame_done
);

  localparam logic [2:0] PH_IDLE  = 3'd0;
  localparam logic [2:0] PH_BURST = 3'd1;
  localparam logic [2:0] PH_PAUSE = 3'd2;
  localparam logic [2:0] PH_FINAL = 3'd3;
  localparam logic [2:0] PH_GAP   = 3'd4;

  logic [2:0] phase, phase_next;
  logic [1:0] load_status_next;
  logic       frame_done_next;
  logic       accept;
  logic       repeat_end;

  assign req_stall = res_valid && res_stall;
  assign accept    = req_valid && !req_stall;
  assign busy      = (phase != PH_IDLE);

  always_comb begin
    cmd              = '0;
    phase_next       = phase;
    load_status_next = ir2pd_pkg::LS_OK;
    frame_done_next  = 1'b0;
    repeat_end       = 1'b0;

    if (accept) begin
      if (req_type == ir2pd_pkg::REQ_TICK) begin
        case (phase)
          PH_BURST: begin
            cmd.burst_step = 1'b1;
            if (stat.burst_done) begin
              cmd.load_pause = 1'b1;
              phase_next     = PH_PAUSE;
            end
          end
          PH_PAUSE: begin
            cmd.interval_dec = 1'b1;
            if (stat.interval_one) begin
              cmd.begin_burst = 1'b1;
              if (stat.last_symbol) begin
                phase_next = PH_FINAL;
              end else begin
                cmd.next_symbol = 1'b1;
                phase_next      = PH_BURST;
              end
            end
          end
          PH_FINAL: begin
            cmd.burst_step = 1'b1;
            if (stat.burst_done) begin
              if (stat.gap_zero) begin
                repeat_end = 1'b1;
              end else begin
                cmd.load_gap = 1'b1;
                phase_next   = PH_GAP;
              end
            end
          end
          PH_GAP: begin
            cmd.interval_dec = 1'b1;
            repeat_end       = stat.interval_one;
          end
          default: ;
        endcase
        if (repeat_end) begin
          if (stat.repeats_le1) begin
            cmd.end_frame   = 1'b1;
            phase_next      = PH_IDLE;
            frame_done_next = 1'b1;
          end else begin
            cmd.restart = 1'b1;
            phase_next  = PH_BURST;
          end
        end
      end else if (phase != PH_IDLE) begin
        load_status_next = ir2pd_pkg::LS_BUSY;
      end else begin
        cmd.load_byte    = !stat.full;
        load_status_next = stat.full ? ir2pd_pkg::LS_FULL : ir2pd_pkg::LS_OK;
        if (last_byte) begin
          if (stat.rep_zero) begin
            cmd.clear_len = 1'b1;
          end else begin
            cmd.start  = 1'b1;
            phase_next = PH_BURST;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_IDLE;
      res_valid   <= 1'b0;
      load_status <= ir2pd_pkg::LS_OK;
      frame_done  <= 1'b0;
    end else begin
      phase <= phase_next;
      if (accept) begin
        res_valid   <= 1'b1;
        load_status <= load_status_next;
        frame_done  <= frame_done_next;
      end else if (!res_stall) begin
        res_valid <= 1'b0;
      end
    end
  end

endmodule

// ----- hdl/ir_two_bit_pulse_distance_modulator_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ir_two_bit_pulse_distance_modulator_unit
// ir transmitter: frame byte loader and tick-driven pulse-distance modulator
// ----------------------------------------------------------------------------
// a result word is registered and appears in the cycle after its request word is taken
// throughput: one request word per cycle while the result side keeps up
// the result register holds one word; requests stall only while it is stalled
// reset (rst, synchronous): idle, empty frame, pin low, registers to defaults
// the frame store needs no clearing; only bytes of the current frame are read
// ----------------------------------------------------------------------------
module ir_two_bit_pulse_distance_modulator_unit #(
  parameter int FRAME_BYTES = 256
) (
  input  logic                             clk,
  input  logic                             rst,
  // request channel
  input  logic                             req_valid,
  output logic                             req_stall,
  input  ir2pd_pkg::req_word_t             req,
  // result channel
  output logic                             res_valid,
  input  logic                             res_stall,
  output ir2pd_pkg::res_word_t             res,
  // configuration write port
  input  logic                             cfg_we,
  input  logic [ir2pd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [ir2pd_pkg::CFG_DATA_W-1:0] cfg_data
);

  ir2pd_pkg::dp_cmd_t  cmd;
  ir2pd_pkg::dp_stat_t stat;
  logic                pin_level;
  logic                busy;
  logic [1:0]          load_status;
  logic                frame_done;

  // controller: phase sequencing, handshake, per-word status
  ir2pd_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .req_valid  (req_valid),
    .req_stall  (req_stall),
    .req_type   (req.req_type),
    .last_byte  (req.last_byte),
    .res_valid  (res_valid),
    .res_stall  (res_stall),
    .stat       (stat),
    .cmd        (cmd),
    .busy       (busy),
    .load_status(load_status),
    .frame_done (frame_done)
  );

  // datapath: frame store, config registers, carrier and interval counters
  ir2pd_dpath #(
    .FRAME_BYTES(FRAME_BYTES)
  ) u_dpath (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .req      (req),
    .cmd      (cmd),
    .stat     (stat),
    .pin_level(pin_level)
  );

  // pin and busy are state after the step; they only move when a new
  // word is taken, which is also when the held result word leaves
  assign res.ir_level    = pin_level;
  assign res.busy_res    = busy;
  assign res.load_status = load_status;
  assign res.frame_done  = frame_done;

endmodule
